// ===== rtl/mdae_pkg.sv =====
// shared types and constants for the multichannel dma address engine
package mdae_pkg;

	localparam int CHANNELS_DEF   = 4;
	localparam int COUNT_BITS_DEF = 17;

	typedef enum logic [1:0] {
		CMD_SETUP   = 2'd0,
		CMD_TRIGGER = 2'd1,
		CMD_BEAT    = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		DIR_INC    = 2'd0,
		DIR_DEC    = 2'd1,
		DIR_FIXED  = 2'd2,
		DIR_RELOAD = 2'd3
	} dir_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		cmd_t        command;
		logic [1:0]  channel;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [16:0] unit_count;
		logic [1:0]  dest_mode;
		logic [1:0]  src_mode;
		logic        word_size;
		logic        repeat_mode;
		logic [1:0]  timing;
		logic        enable;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]  out_channel;
		logic [31:0] read_addr;
		logic [31:0] write_addr;
		logic        unit_is_word;
		logic        last_unit;
	} xfer_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic has_result;
	} sts_t;

endpackage

// ===== rtl/multichannel_dma_address_engine.sv =====
// top level of the multichannel dma address engine
// a command is captured in the idle state and executed in the execute state
// a beat's transfer is registered into the output register when the beat executes
// a new command is taken only in the idle state; cmd_stall holds it off during execution
// a beat waits in execution only while the previous transfer is still unread
// asynchronous reset clears every channel register at once; no clearing pass
module multichannel_dma_address_engine import mdae_pkg::*; #(
	parameter int CHANNELS   = CHANNELS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  cmd_item_t  cmd_data,
	output logic       xfer_valid,
	input  logic       xfer_stall,
	output xfer_item_t xfer_data
);

	ctl_t ctl;
	sts_t sts;

	mdae_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.xfer_valid (xfer_valid),
		.xfer_stall (xfer_stall),
		.sts        (sts),
		.ctl        (ctl)
	);

	mdae_datapath #(
		.CHANNELS   (CHANNELS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_data  (cmd_data),
		.ctl       (ctl),
		.sts       (sts),
		.xfer_data (xfer_data)
	);

endmodule

// ===== rtl/mdae_ctrl.sv =====
// controller: command sequencing and output valid tracking
module mdae_ctrl import mdae_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cmd_valid,
	output logic   cmd_stall,
	output logic   xfer_valid,
	input  logic   xfer_stall,
	input  sts_t   sts,
	output ctl_t   ctl
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ctl.load    = 1'b0;
		ctl.exec    = 1'b0;
		cmd_stall   = 1'b0;
		out_valid_d = out_valid_q;
		if (out_valid_q && !xfer_stall)
			out_valid_d = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd_stall = 1'b1;
				// hold the beat while the previous result is still unread
				if (!(sts.has_result && out_valid_q && xfer_stall)) begin
					ctl.exec = 1'b1;
					state_d  = ST_IDLE;
					if (sts.has_result)
						out_valid_d = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign xfer_valid = out_valid_q;

endmodule

// ===== rtl/mdae_datapath.sv =====
// datapath: per-channel address, count and mode registers, beat and trigger logic
module mdae_datapath import mdae_pkg::*; #(
	parameter int CHANNELS   = CHANNELS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_item_t  cmd_data,
	input  ctl_t       ctl,
	output sts_t       sts,
	output xfer_item_t xfer_data
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	cmd_item_t item_q;
	xfer_item_t out_q;

	logic [31:0]           src_q  [CHANNELS];
	logic [31:0]           dst_q  [CHANNELS];
	logic [31:0]           rld_q  [CHANNELS];
	logic [COUNT_BITS-1:0] left_q [CHANNELS];
	logic [COUNT_BITS-1:0] cnt_q  [CHANNELS];
	dir_t                  dmode_q[CHANNELS];
	logic [1:0]            smode_q[CHANNELS];
	logic                  word_q [CHANNELS];
	logic                  rpt_q  [CHANNELS];
	logic [1:0]            tim_q  [CHANNELS];
	logic [CHANNELS-1:0]   act_q, ren_q, pend_q;

	logic [31:0]           src_d  [CHANNELS];
	logic [31:0]           dst_d  [CHANNELS];
	logic [31:0]           rld_d  [CHANNELS];
	logic [COUNT_BITS-1:0] left_d [CHANNELS];
	logic [COUNT_BITS-1:0] cnt_d  [CHANNELS];
	dir_t                  dmode_d[CHANNELS];
	logic [1:0]            smode_d[CHANNELS];
	logic                  word_d [CHANNELS];
	logic                  rpt_d  [CHANNELS];
	logic [1:0]            tim_d  [CHANNELS];
	logic [CHANNELS-1:0]   act_d, ren_d, pend_d;

	logic [CH_W-1:0] sel;
	logic            found;
	logic            ch_ok;
	logic [CH_W-1:0] ch_idx;
	logic [31:0]     step;
	logic            last;
	logic            fire;
	logic [1:0]      fire_t;

	always_ff @(posedge clk) begin
		if (ctl.load)
			item_q <= cmd_data;
	end

	// lowest pending channel wins
	always_comb begin
		sel   = '0;
		found = 1'b0;
		for (int c = CHANNELS - 1; c >= 0; c--) begin
			if (pend_q[c]) begin
				sel   = CH_W'(c);
				found = 1'b1;
			end
		end
	end

	assign ch_ok  = 32'(item_q.channel) < CHANNELS;
	assign ch_idx = CH_W'(item_q.channel);
	assign step   = word_q[sel] ? 32'd4 : 32'd2;
	assign last   = left_q[sel] <= COUNT_BITS'(1);
	assign sts.has_result = (item_q.command == CMD_BEAT) && found;

	always_comb begin
		src_d   = src_q;
		dst_d   = dst_q;
		rld_d   = rld_q;
		left_d  = left_q;
		cnt_d   = cnt_q;
		dmode_d = dmode_q;
		smode_d = smode_q;
		word_d  = word_q;
		rpt_d   = rpt_q;
		tim_d   = tim_q;
		act_d   = act_q;
		ren_d   = ren_q;
		pend_d  = pend_q;
		fire    = 1'b0;
		fire_t  = 2'd0;
		case (item_q.command)
			CMD_SETUP: begin
				if (ch_ok) begin
					src_d[ch_idx]   = item_q.src_addr;
					dst_d[ch_idx]   = item_q.dst_addr;
					rld_d[ch_idx]   = item_q.dst_addr;
					left_d[ch_idx]  = COUNT_BITS'(item_q.unit_count);
					cnt_d[ch_idx]   = COUNT_BITS'(item_q.unit_count);
					dmode_d[ch_idx] = dir_t'(item_q.dest_mode);
					smode_d[ch_idx] = item_q.src_mode;
					word_d[ch_idx]  = item_q.word_size;
					rpt_d[ch_idx]   = item_q.repeat_mode;
					tim_d[ch_idx]   = item_q.timing;
					act_d[ch_idx]   = item_q.enable;
					ren_d[ch_idx]   = item_q.enable;
					pend_d[ch_idx]  = 1'b0;
					fire            = 1'b1;
				end
			end
			CMD_TRIGGER: begin
				fire   = 1'b1;
				fire_t = item_q.timing;
			end
			CMD_CLEAR: begin
				if (ch_ok)
					ren_d[ch_idx] = 1'b0;
			end
			CMD_BEAT: begin
				if (found) begin
					case (dmode_q[sel])
						DIR_INC, DIR_RELOAD: dst_d[sel] = dst_q[sel] + step;
						DIR_DEC:             dst_d[sel] = dst_q[sel] - step;
						default:             dst_d[sel] = dst_q[sel];
					endcase
					case (smode_q[sel])
						DIR_INC: src_d[sel] = src_q[sel] + step;
						DIR_DEC: src_d[sel] = src_q[sel] - step;
						default: src_d[sel] = src_q[sel];
					endcase
					left_d[sel] = last ? '0 : left_q[sel] - COUNT_BITS'(1);
					if (last) begin
						pend_d[sel] = 1'b0;
						if (rpt_q[sel]) begin
							left_d[sel] = cnt_q[sel];
							if (dmode_q[sel] == DIR_RELOAD)
								dst_d[sel] = rld_q[sel];
						end else begin
							act_d[sel] = 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
		// start-timing event over all channels, after any set-up write
		if (fire) begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (!ren_d[c])
					act_d[c] = 1'b0;
				if (act_d[c] && !pend_d[c] && tim_d[c] == fire_t) begin
					if (left_d[c] == '0) begin
						// empty run completes at once
						if (rpt_d[c]) begin
							left_d[c] = cnt_d[c];
							if (dmode_d[c] == DIR_RELOAD)
								dst_d[c] = rld_d[c];
						end else begin
							act_d[c] = 1'b0;
						end
					end else begin
						pend_d[c] = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				src_q[c]   <= '0;
				dst_q[c]   <= '0;
				rld_q[c]   <= '0;
				left_q[c]  <= '0;
				cnt_q[c]   <= '0;
				dmode_q[c] <= DIR_INC;
				smode_q[c] <= '0;
				word_q[c]  <= 1'b0;
				rpt_q[c]   <= 1'b0;
				tim_q[c]   <= '0;
			end
			act_q  <= '0;
			ren_q  <= '0;
			pend_q <= '0;
		end else if (ctl.exec) begin
			src_q   <= src_d;
			dst_q   <= dst_d;
			rld_q   <= rld_d;
			left_q  <= left_d;
			cnt_q   <= cnt_d;
			dmode_q <= dmode_d;
			smode_q <= smode_d;
			word_q  <= word_d;
			rpt_q   <= rpt_d;
			tim_q   <= tim_d;
			act_q   <= act_d;
			ren_q   <= ren_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec && sts.has_result) begin
			out_q.out_channel  <= 2'(sel);
			out_q.read_addr    <= src_q[sel];
			out_q.write_addr   <= dst_q[sel];
			out_q.unit_is_word <= word_q[sel];
			out_q.last_unit    <= last;
		end
	end

	assign xfer_data = out_q;

endmodule

// ===== verif/mdae_checker.sv =====
// transfer predictor and scoreboard for the multichannel dma address engine
`timescale 1ns / 1ps
module mdae_checker import mdae_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  logic       cmd_stall,
	input  cmd_item_t  cmd_data,
	input  logic       xfer_valid,
	input  logic       xfer_stall,
	input  xfer_item_t xfer_data,
	output int         errors,
	output int         outstanding
);

	localparam int CH = CHANNELS_DEF;

	// per-channel copy of the engine state
	logic [31:0] src_cur [CH];
	logic [31:0] dst_cur [CH];
	logic [31:0] dst_reload [CH];
	logic [16:0] units_left [CH];
	logic [16:0] count_reload [CH];
	dir_t        dst_dir [CH];
	dir_t        src_dir [CH];
	logic        word_unit [CH];
	logic        repeats [CH];
	logic [1:0]  start_timing [CH];
	logic        active [CH];
	logic        reg_enabled [CH];
	logic        pending [CH];

	xfer_item_t expected_xfers[$];
	int fail_total = 0;

	task automatic report(input string msg);
		fail_total++;
		if (fail_total <= 30)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	function automatic logic [31:0] stepped(logic [31:0] a, dir_t d, logic word);
		logic [31:0] size;
		size = word ? 32'd4 : 32'd2;
		case (d)
			DIR_INC: return a + size;
			DIR_DEC: return a - size;
			default: return a;
		endcase
	endfunction

	task automatic end_run(input int c);
		pending[c] = 1'b0;
		if (repeats[c]) begin
			units_left[c] = count_reload[c];
			if (dst_dir[c] == DIR_RELOAD)
				dst_cur[c] = dst_reload[c];
		end else begin
			active[c] = 1'b0;
		end
	endtask

	task automatic fire_timing(input logic [1:0] t);
		for (int c = 0; c < CH; c++) begin
			if (!reg_enabled[c])
				active[c] = 1'b0;
			if (active[c] && !pending[c] && start_timing[c] == t) begin
				if (units_left[c] == 0)
					end_run(c);
				else
					pending[c] = 1'b1;
			end
		end
	endtask

	task automatic apply_command(input cmd_item_t it);
		int c;
		xfer_item_t x;
		c = -1;
		case (it.command)
			CMD_SETUP: begin
				c = int'(it.channel);
				src_cur[c]      = it.src_addr;
				dst_cur[c]      = it.dst_addr;
				dst_reload[c]   = it.dst_addr;
				units_left[c]   = it.unit_count;
				count_reload[c] = it.unit_count;
				dst_dir[c]      = dir_t'(it.dest_mode);
				src_dir[c]      = dir_t'(it.src_mode);
				word_unit[c]    = it.word_size;
				repeats[c]      = it.repeat_mode;
				start_timing[c] = it.timing;
				reg_enabled[c]  = it.enable;
				active[c]       = it.enable;
				pending[c]      = 1'b0;
				fire_timing(2'd0);
			end
			CMD_TRIGGER: fire_timing(it.timing);
			CMD_CLEAR: reg_enabled[it.channel] = 1'b0;
			default: begin
				// lowest pending channel wins the beat
				for (int k = CH - 1; k >= 0; k--)
					if (pending[k])
						c = k;
				if (c >= 0) begin
					x.out_channel  = c[1:0];
					x.read_addr    = src_cur[c];
					x.write_addr   = dst_cur[c];
					x.unit_is_word = word_unit[c];
					x.last_unit    = units_left[c] <= 1;
					expected_xfers.push_back(x);
					// reload mode steps the destination upwards during the run
					dst_cur[c] = stepped(dst_cur[c],
						dst_dir[c] == DIR_RELOAD ? DIR_INC : dst_dir[c], word_unit[c]);
					src_cur[c] = stepped(src_cur[c], src_dir[c], word_unit[c]);
					if (x.last_unit) begin
						units_left[c] = '0;
						end_run(c);
					end else begin
						units_left[c] = units_left[c] - 17'd1;
					end
				end
			end
		endcase
	endtask

	task automatic check_xfer(input xfer_item_t got);
		xfer_item_t exp;
		if (expected_xfers.size() == 0) begin
			report($sformatf("unexpected transaction on channel %0d", got.out_channel));
		end else begin
			exp = expected_xfers.pop_front();
			if (got.out_channel !== exp.out_channel)
				report($sformatf("out_channel %0d, want %0d", got.out_channel, exp.out_channel));
			if (got.read_addr !== exp.read_addr)
				report($sformatf("read_addr %h, want %h", got.read_addr, exp.read_addr));
			if (got.write_addr !== exp.write_addr)
				report($sformatf("write_addr %h, want %h", got.write_addr, exp.write_addr));
			if (got.unit_is_word !== exp.unit_is_word)
				report($sformatf("unit_is_word %b, want %b", got.unit_is_word,
					exp.unit_is_word));
			if (got.last_unit !== exp.last_unit)
				report($sformatf("last_unit %b, want %b", got.last_unit, exp.last_unit));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CH; c++) begin
				src_cur[c]      = '0;
				dst_cur[c]      = '0;
				dst_reload[c]   = '0;
				units_left[c]   = '0;
				count_reload[c] = '0;
				dst_dir[c]      = DIR_INC;
				src_dir[c]      = DIR_INC;
				word_unit[c]    = 1'b0;
				repeats[c]      = 1'b0;
				start_timing[c] = 2'd0;
				active[c]       = 1'b0;
				reg_enabled[c]  = 1'b0;
				pending[c]      = 1'b0;
			end
			expected_xfers.delete();
			outstanding <= 0;
			errors <= fail_total;
		end else begin
			// results in flight belong to earlier commands, so compare first
			if (xfer_valid && !xfer_stall)
				check_xfer(xfer_data);
			if (cmd_valid && !cmd_stall)
				apply_command(cmd_data);
			outstanding <= expected_xfers.size();
			errors <= fail_total;
		end
	end

endmodule

// ===== verif/tb_top.sv =====
// stimulus, handshake pacing and verdict for the multichannel dma address engine
`timescale 1ns / 1ps
module tb_top;
	import mdae_pkg::*;

	localparam int LIMIT   = 400000;
	localparam int N_ITEMS = 1850;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	cmd_item_t  cmd_data = '0;
	logic       xfer_valid;
	logic       xfer_stall = 1'b0;
	xfer_item_t xfer_data;

	int errors;
	int outstanding;
	int cycles = 0;
	int n_sent = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	bit hold_used = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	multichannel_dma_address_engine u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd_data   (cmd_data),
		.xfer_valid (xfer_valid),
		.xfer_stall (xfer_stall),
		.xfer_data  (xfer_data)
	);

	mdae_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd_data    (cmd_data),
		.xfer_valid  (xfer_valid),
		.xfer_stall  (xfer_stall),
		.xfer_data   (xfer_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// receiver: random stalls, none while quiet, one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				xfer_stall <= 1'b1;
				repeat (300) @(negedge clk);
				hold_req = 1'b0;
				xfer_stall <= 1'b0;
			end else begin
				xfer_stall <= !quiet && ($urandom_range(99) < 24);
			end
		end
	end

	task automatic send(input cmd_item_t it);
		if (!quiet && $urandom_range(99) < 24) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data <= it;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		n_sent++;
	endtask

	// every field random, the command forced
	function automatic cmd_item_t rand_cmd(input cmd_t c);
		cmd_item_t it;
		it.command     = c;
		it.channel     = 2'($urandom_range(3));
		it.src_addr    = $urandom;
		it.dst_addr    = $urandom;
		it.unit_count  = 17'($urandom_range(17'h1FFFF));
		it.dest_mode   = 2'($urandom_range(3));
		it.src_mode    = 2'($urandom_range(3));
		it.word_size   = 1'($urandom_range(1));
		it.repeat_mode = 1'($urandom_range(1));
		it.timing      = 2'($urandom_range(3));
		it.enable      = 1'($urandom_range(1));
		return it;
	endfunction

	function automatic cmd_item_t setup_item(input logic [1:0] ch, input logic [31:0] src,
		input logic [31:0] dst, input logic [16:0] cnt, input dir_t dm, input dir_t sm,
		input logic word, input logic rep, input logic [1:0] tim, input logic en);
		cmd_item_t it;
		it = rand_cmd(CMD_SETUP);
		it.channel     = ch;
		it.src_addr    = src;
		it.dst_addr    = dst;
		it.unit_count  = cnt;
		it.dest_mode   = dm;
		it.src_mode    = sm;
		it.word_size   = word;
		it.repeat_mode = rep;
		it.timing      = tim;
		it.enable      = en;
		return it;
	endfunction

	function automatic cmd_item_t trigger_item(input logic [1:0] t);
		cmd_item_t it;
		it = rand_cmd(CMD_TRIGGER);
		it.timing = t;
		return it;
	endfunction

	function automatic cmd_item_t clear_item(input logic [1:0] ch);
		cmd_item_t it;
		it = rand_cmd(CMD_CLEAR);
		it.channel = ch;
		return it;
	endfunction

	initial begin
		cmd_item_t it;
		int r;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part
		send(rand_cmd(CMD_BEAT));
		// source wraps upwards, destination wraps downwards
		send(setup_item(2'd0, 32'hFFFF_FFFC, 32'h0, 17'd3, DIR_DEC, DIR_INC, 1'b1, 1'b0,
			2'd0, 1'b1));
		repeat (4) send(rand_cmd(CMD_BEAT));
		send(setup_item(2'd1, 32'h0, 32'h1000, 17'd2, DIR_RELOAD, DIR_DEC, 1'b0, 1'b1,
			2'd2, 1'b1));
		send(trigger_item(2'd2));
		// zero count finishes as soon as it is triggered
		send(setup_item(2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd0, DIR_FIXED, DIR_FIXED,
			1'b0, 1'b0, 2'd1, 1'b1));
		send(trigger_item(2'd1));
		send(trigger_item(2'd2));
		repeat (2) send(rand_cmd(CMD_BEAT));
		send(clear_item(2'd1));
		send(trigger_item(2'd2));
		send(rand_cmd(CMD_BEAT));
		// src mode 3 behaves as fixed
		send(setup_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF, DIR_FIXED,
			DIR_RELOAD, 1'b1, 1'b1, 2'd3, 1'b1));
		send(trigger_item(2'd3));
		// clearing the enable lets the pending run carry on
		send(clear_item(2'd3));
		send(rand_cmd(CMD_BEAT));
		send(setup_item(2'd3, 32'h0, 32'h0, 17'd1, DIR_INC, DIR_INC, 1'b0, 1'b0,
			2'd3, 1'b0));
		send(setup_item(2'd0, 32'h8000_0000, 32'h2000, 17'd1, DIR_RELOAD, DIR_DEC, 1'b0,
			1'b1, 2'd0, 1'b1));
		send(rand_cmd(CMD_BEAT));
		send(trigger_item(2'd0));
		send(rand_cmd(CMD_BEAT));

		// random part: mostly set-up, trigger, beats; the rest noise
		while (n_sent < N_ITEMS) begin
			quiet = (n_sent >= 400 && n_sent < 650);
			if (!hold_used && n_sent >= 1000) begin
				hold_used = 1'b1;
				it = setup_item(2'd0, $urandom, $urandom, 17'd40, dir_t'($urandom_range(3)),
					dir_t'($urandom_range(3)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 2'd0, 1'b1);
				send(it);
				// receiver holds off while beats keep coming, so the engine backs up
				hold_req = 1'b1;
				repeat (45) send(rand_cmd(CMD_BEAT));
			end
			r = $urandom_range(99);
			if (r < 55) begin
				it = rand_cmd(CMD_SETUP);
				it.enable = ($urandom_range(9) != 0);
				if ($urandom_range(9) != 0)
					it.unit_count = 17'($urandom_range(6));
				send(it);
				if (it.timing != 2'd0 && $urandom_range(4) != 0)
					send(trigger_item(it.timing));
				repeat ($urandom_range(1, 8)) send(rand_cmd(CMD_BEAT));
			end else if (r < 70) begin
				send(trigger_item(2'($urandom_range(3))));
			end else if (r < 80) begin
				send(clear_item(2'($urandom_range(3))));
			end else begin
				send(rand_cmd(cmd_t'($urandom_range(3))));
			end
		end
		quiet = 1'b0;

		@(negedge clk);
		cmd_valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
